/* hdl/uds_pkg.sv */
package uds_pkg;

  localparam int MAX_REQUEST_BYTES = 256;
  localparam int BIDX_W = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int CMP_W  = (BIDX_W + 1 > 7) ? BIDX_W + 1 : 7;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;

  localparam logic [2:0] REG_REQUEST_ID   = 3'd0;
  localparam logic [2:0] REG_MAX_DL_SIZE  = 3'd1;
  localparam logic [2:0] REG_MAIN_START   = 3'd2;
  localparam logic [2:0] REG_BACKUP_START = 3'd3;
  localparam logic [2:0] REG_BACKUP_END   = 3'd4;

  localparam logic [10:0] RST_REQUEST_ID   = 11'h7E0;
  localparam logic [23:0] RST_MAX_DL_SIZE  = 24'd24576;
  localparam logic [31:0] RST_MAIN_START   = 32'h0800_4000;
  localparam logic [31:0] RST_BACKUP_START = 32'h0801_0000;
  localparam logic [31:0] RST_BACKUP_END   = 32'h0801_C000;

  localparam logic [1:0] KIND_RESP  = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_EXIT  = 2'd3;

  localparam logic [7:0] SID_SESSION  = 8'h10;
  localparam logic [7:0] SID_RESET    = 8'h11;
  localparam logic [7:0] SID_DOWNLOAD = 8'h34;
  localparam logic [7:0] SID_TRANSFER = 8'h36;
  localparam logic [7:0] SID_EXIT     = 8'h37;
  localparam logic [7:0] SID_TESTER   = 8'h3E;
  localparam logic [7:0] POS_OFFSET   = 8'h40;
  localparam logic [7:0] NEG_RESP     = 8'h7F;

  localparam logic [7:0] NRC_UNKNOWN_SERVICE = 8'h11;
  localparam logic [7:0] NRC_UNKNOWN_SESSION = 8'h12;
  localparam logic [7:0] NRC_BAD_LENGTH      = 8'h13;
  localparam logic [7:0] NRC_NOT_PROGRAMMING = 8'h22;
  localparam logic [7:0] NRC_OUT_OF_RANGE    = 8'h31;
  localparam logic [7:0] NRC_WRONG_BLOCK     = 8'h33;
  localparam logic [7:0] NRC_COUNT_MISMATCH  = 8'h72;

  localparam logic [1:0] SESS_PROGRAMMING = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] flash_address;
    logic        partition;
    logic [31:0] received_crc;
    logic        response_last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] value, logic [31:0] addr,
                                  logic part, logic [31:0] crc, logic lastr);
    res_t r;
    r.kind          = kind;
    r.value         = value;
    r.flash_address = addr;
    r.partition     = part;
    r.received_crc  = crc;
    r.response_last = lastr;
    return r;
  endfunction

  function automatic res_t resp_byte(logic [7:0] value, logic lastr);
    return mk_res(KIND_RESP, value, 32'd0, 1'b0, 32'd0, lastr);
  endfunction

endpackage

/* hdl/uds_bootloader_request_server_top.sv */
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: frame_id[10:0], request_byte[18:11]; tlast: last_byte
// m_axis   | out | tdata: value, flash_address, partition, received_crc; tuser: kind;
//          |     | tlast: response_last
// cfg      | in  | cfg_we_i / cfg_index_i / cfg_data_i, one register per write
//
// Each request byte is processed into a 4-entry result buffer when it is accepted.
// A byte with at most one result streams at one per cycle unless the output stalls;
// for n results, input waits as the buffer drains one beat per unstalled cycle.
// Input is taken when the buffer is empty or its last beat leaves this cycle.
// Reset (rst_ni low, async) clears session/download state and loads register defaults.
module uds_bootloader_request_server_top
  import uds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // frame_id, request_byte, zero pad
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // value, flash_address, partition,
                                                 // received_crc, zero pad
  output logic [1:0]            m_axis_tuser_o,  // kind
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  logic [10:0] req_id_q;
  logic [23:0] max_size_q;
  logic [31:0] main_start_q, backup_start_q, backup_end_q;

  logic [1:0]        session_q, session_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  logic [7:0]        sid_q, sid_d, sb_q, sb_d, exp_blk_q, exp_blk_d;
  logic              fa_q, fa_d, tpart_q, tpart_d;
  logic [3:0]        alen_q, alen_d, slen_q, slen_d;
  logic [31:0]       addr_acc_q, addr_acc_d, size_acc_q, size_acc_d;
  logic [31:0]       dl_start_q, dl_start_d, dl_len_q, dl_len_d;
  logic [31:0]       rcv_q, rcv_d, crc_q, crc_d;

  res_t       res_q [4];
  res_t       list  [4];
  res_t       fin   [4];
  logic [2:0] cnt_q, n_d;
  logic [1:0] head_q;
  logic [2:0] fn;

  logic in_fire, out_fire;
  logic [10:0] fid;
  logic [7:0]  b;
  logic        wr_en;
  res_t        wr_res;
  logic [CMP_W-1:0] idx_c, len_c, lim_a, lim_s;

  assign fid      = s_axis_tdata_i[10:0];
  assign b        = s_axis_tdata_i[18:11];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == 3'd0) || (cnt_q == 3'd1 && m_axis_tready_i);
  assign m_axis_tvalid_o = cnt_q != 3'd0;
  assign m_axis_tuser_o  = res_q[head_q].kind;
  assign m_axis_tlast_o  = res_q[head_q].response_last;
  assign m_axis_tdata_o  = {7'd0, res_q[head_q].received_crc, res_q[head_q].partition,
                            res_q[head_q].flash_address, res_q[head_q].value};

  always_comb begin
    session_d  = session_q;  bidx_d     = bidx_q;     sid_d    = sid_q;
    sb_d       = sb_q;       exp_blk_d  = exp_blk_q;  fa_d     = fa_q;
    tpart_d    = tpart_q;    alen_d     = alen_q;     slen_d   = slen_q;
    addr_acc_d = addr_acc_q; size_acc_d = size_acc_q; dl_start_d = dl_start_q;
    dl_len_d   = dl_len_q;   rcv_d      = rcv_q;      crc_d    = crc_q;
    wr_en  = 1'b0;
    wr_res = mk_res(KIND_WRITE, b, dl_start_q + rcv_q, tpart_q, 32'd0, 1'b0);
    fn     = 3'd0;
    for (int i = 0; i < 4; i++) fin[i] = resp_byte(8'd0, 1'b0);
    idx_c = CMP_W'(bidx_q);
    len_c = idx_c + CMP_W'(1);
    lim_a = CMP_W'(3) + CMP_W'(alen_q);
    lim_s = lim_a + CMP_W'(slen_q);

    if (fid == req_id_q) begin
      if (bidx_q == '0) begin
        fa_d = 1'b1; sid_d = b; sb_d = 8'd0; alen_d = 4'd0; slen_d = 4'd0;
        addr_acc_d = 32'd0; size_acc_d = 32'd0; crc_d = 32'd0;
      end
      if (idx_c >= CMP_W'(MAX_REQUEST_BYTES)) fa_d = 1'b0;

      if (fa_d) begin
        if (idx_c == CMP_W'(1)) sb_d = b;
        if (sid_d == SID_DOWNLOAD) begin
          if (idx_c == CMP_W'(2)) begin
            alen_d = b[3:0];
            slen_d = b[7:4];
          end else if (idx_c >= CMP_W'(3) && idx_c < lim_a) begin
            addr_acc_d = {addr_acc_d[23:0], b};
          end else if (idx_c >= lim_a && idx_c < lim_s) begin
            size_acc_d = {size_acc_d[23:0], b};
          end
        end
        if (sid_d == SID_EXIT) begin
          case (idx_c)
            CMP_W'(1): crc_d[31:24] = crc_d[31:24] | b;
            CMP_W'(2): crc_d[23:16] = crc_d[23:16] | b;
            CMP_W'(3): crc_d[15:8]  = crc_d[15:8]  | b;
            CMP_W'(4): crc_d[7:0]   = crc_d[7:0]   | b;
            default: ;
          endcase
        end
        if (sid_d == SID_TRANSFER && idx_c >= CMP_W'(2) && sb_d == exp_blk_q &&
            session_q == SESS_PROGRAMMING) begin
          wr_en = 1'b1;
          rcv_d = rcv_q + 32'd1;
        end
      end

      if (s_axis_tlast_i) begin
        if (fa_d) begin
          // negative response layout, overwritten by positive paths below
          fn = 3'd3;
          fin[0] = resp_byte(NEG_RESP, 1'b0);
          fin[1] = resp_byte(sid_d, 1'b0);
          fin[2] = resp_byte(NRC_UNKNOWN_SERVICE, 1'b1);
          case (sid_d)
            SID_SESSION: begin
              if (len_c < CMP_W'(2)) begin
                fin[2] = resp_byte(NRC_BAD_LENGTH, 1'b1);
              end else if (sb_d < 8'd1 || sb_d > 8'd3) begin
                fin[2] = resp_byte(NRC_UNKNOWN_SESSION, 1'b1);
              end else begin
                session_d = 2'(sb_d - 8'd1);
                fn = 3'd2;
                fin[0] = resp_byte(SID_SESSION + POS_OFFSET, 1'b0);
                fin[1] = resp_byte(sb_d, 1'b1);
              end
            end
            SID_TESTER: begin
              fn = 3'd1;
              fin[0] = resp_byte(SID_TESTER + POS_OFFSET, 1'b1);
            end
            SID_RESET: begin
              fn = 3'd2;
              fin[0] = resp_byte(SID_RESET + POS_OFFSET, 1'b0);
              fin[1] = resp_byte(8'h01, 1'b1);
            end
            SID_DOWNLOAD: begin
              if (len_c < CMP_W'(5) || len_c < CMP_W'(3) + CMP_W'(alen_d) + CMP_W'(slen_d)) begin
                fin[2] = resp_byte(NRC_BAD_LENGTH, 1'b1);
              end else begin
                dl_start_d = addr_acc_d;
                dl_len_d   = size_acc_d;
                if (size_acc_d > {8'd0, max_size_q}) begin
                  fin[2] = resp_byte(NRC_BAD_LENGTH, 1'b1);
                end else begin
                  rcv_d = 32'd0;
                  exp_blk_d = 8'd1;
                  if ((addr_acc_d >= main_start_q && addr_acc_d < backup_start_q) ||
                      (addr_acc_d >= backup_start_q && addr_acc_d < backup_end_q)) begin
                    tpart_d = !(addr_acc_d >= main_start_q && addr_acc_d < backup_start_q);
                    fn = 3'd4;
                    fin[0] = mk_res(KIND_ERASE, 8'd0, 32'd0, tpart_d, 32'd0, 1'b0);
                    fin[1] = resp_byte(SID_DOWNLOAD + POS_OFFSET, 1'b0);
                    fin[2] = resp_byte(8'h02, 1'b0);
                    fin[3] = resp_byte(8'h00, 1'b1);
                  end else begin
                    fin[2] = resp_byte(NRC_OUT_OF_RANGE, 1'b1);
                  end
                end
              end
            end
            SID_TRANSFER: begin
              if (len_c <= CMP_W'(2)) begin
                fin[2] = resp_byte(NRC_BAD_LENGTH, 1'b1);
              end else if (sb_d != exp_blk_q) begin
                fin[2] = resp_byte(NRC_WRONG_BLOCK, 1'b1);
              end else if (session_q != SESS_PROGRAMMING) begin
                fin[2] = resp_byte(NRC_NOT_PROGRAMMING, 1'b1);
              end else begin
                exp_blk_d = exp_blk_q + 8'd1;
                fn = 3'd2;
                fin[0] = resp_byte(SID_TRANSFER + POS_OFFSET, 1'b0);
                fin[1] = resp_byte(sb_d, 1'b1);
              end
            end
            SID_EXIT: begin
              fin[0] = mk_res(KIND_EXIT, 8'd0, 32'd0, 1'b0, crc_d, 1'b0);
              if (rcv_d == dl_len_q) begin
                fn = 3'd2;
                fin[1] = resp_byte(SID_EXIT + POS_OFFSET, 1'b1);
              end else begin
                fn = 3'd4;
                fin[1] = resp_byte(NEG_RESP, 1'b0);
                fin[2] = resp_byte(SID_EXIT, 1'b0);
                fin[3] = resp_byte(NRC_COUNT_MISMATCH, 1'b1);
              end
            end
            default: ;
          endcase
        end
        bidx_d = '0;
        fa_d   = 1'b0;
      end else if (idx_c < CMP_W'(MAX_REQUEST_BYTES)) begin
        bidx_d = bidx_q + BIDX_W'(1);
      end
    end

    // flash write, if any, goes ahead of the service's results
    if (wr_en) begin
      list[0] = wr_res;
      list[1] = fin[0];
      list[2] = fin[1];
      list[3] = fin[2];
      n_d = fn + 3'd1;
    end else begin
      list = fin;
      n_d  = fn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_id_q <= RST_REQUEST_ID;   max_size_q     <= RST_MAX_DL_SIZE;
      main_start_q <= RST_MAIN_START; backup_start_q <= RST_BACKUP_START;
      backup_end_q <= RST_BACKUP_END;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_REQUEST_ID:   req_id_q       <= cfg_data_i[10:0];
        REG_MAX_DL_SIZE:  max_size_q     <= cfg_data_i[23:0];
        REG_MAIN_START:   main_start_q   <= cfg_data_i;
        REG_BACKUP_START: backup_start_q <= cfg_data_i;
        REG_BACKUP_END:   backup_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q <= '0; bidx_q <= '0; sid_q <= '0; sb_q <= '0; exp_blk_q <= '0;
      fa_q <= 1'b0; tpart_q <= 1'b0; alen_q <= '0; slen_q <= '0;
      addr_acc_q <= '0; size_acc_q <= '0; dl_start_q <= '0; dl_len_q <= '0;
      rcv_q <= '0; crc_q <= '0;
      cnt_q <= '0; head_q <= '0;
    end else begin
      if (in_fire) begin
        session_q <= session_d; bidx_q <= bidx_d; sid_q <= sid_d; sb_q <= sb_d;
        exp_blk_q <= exp_blk_d; fa_q <= fa_d; tpart_q <= tpart_d;
        alen_q <= alen_d; slen_q <= slen_d;
        addr_acc_q <= addr_acc_d; size_acc_q <= size_acc_d;
        dl_start_q <= dl_start_d; dl_len_q <= dl_len_d;
        rcv_q <= rcv_d; crc_q <= crc_d;
        cnt_q  <= n_d;
        head_q <= '0;
      end else if (out_fire) begin
        cnt_q  <= cnt_q - 3'd1;
        head_q <= head_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= list;
  end

endmodule

/* hdl/uds_checker.sv */
module uds_checker
  import uds_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]            m_axis_tuser_o,
  input logic                  m_axis_tlast_o
);

  // a pending beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // input is only held off by a result still waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

  a_last_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == KIND_RESP)
    else $error("response_last on non-response beat");

  a_addr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_WRITE |-> m_axis_tdata_o[39:8] == 32'd0)
    else $error("flash address on non-write beat");

endmodule

bind uds_bootloader_request_server_top uds_checker u_uds_checker (.*);

/* bench/uds_server_checker.sv */
module uds_server_checker
  import uds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic [1:0]            m_axis_tuser_i,
  input  logic                  m_axis_tlast_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  res_t pending_results[$];

  logic [10:0] req_id;
  logic [23:0] max_size;
  logic [31:0] main_lo, backup_lo, backup_hi;

  logic [1:0]  session;
  logic [8:0]  byte_idx;
  logic [7:0]  sid, second;
  logic        accepted;
  logic [3:0]  addr_len, size_len;
  logic [31:0] addr_acc, size_acc, dl_start, dl_len, rx_count, crc_acc;
  logic [7:0]  next_block;
  logic        part;

  assign pending_o = pending_results.size();

  function automatic res_t mk(logic [1:0] k, logic [7:0] v, logic [31:0] a, logic p,
                              logic [31:0] c, logic l);
    res_t r;
    r.kind = k; r.value = v; r.flash_address = a; r.partition = p;
    r.received_crc = c; r.response_last = l;
    return r;
  endfunction

  task automatic push_resp(logic [7:0] v, logic l);
    pending_results.push_back(mk(KIND_RESP, v, 32'd0, 1'b0, 32'd0, l));
  endtask

  task automatic push_neg(logic [7:0] code);
    push_resp(NEG_RESP, 1'b0);
    push_resp(sid, 1'b0);
    push_resp(code, 1'b1);
  endtask

  task automatic serve_request(int len);
    case (sid)
      SID_SESSION: begin
        if (len < 2) push_neg(NRC_BAD_LENGTH);
        else if (second < 1 || second > 3) push_neg(NRC_UNKNOWN_SESSION);
        else begin
          session = second[1:0] - 2'd1;
          push_resp(SID_SESSION + POS_OFFSET, 1'b0);
          push_resp(second, 1'b1);
        end
      end
      SID_TESTER: push_resp(SID_TESTER + POS_OFFSET, 1'b1);
      SID_RESET: begin
        push_resp(SID_RESET + POS_OFFSET, 1'b0);
        push_resp(8'h01, 1'b1);
      end
      SID_DOWNLOAD: begin
        if (len < 5 || len < 3 + addr_len + size_len) push_neg(NRC_BAD_LENGTH);
        else begin
          dl_start = addr_acc;
          dl_len   = size_acc;
          if (dl_len > {8'd0, max_size}) push_neg(NRC_BAD_LENGTH);
          else begin
            rx_count   = 0;
            next_block = 8'd1;
            if (dl_start >= main_lo && dl_start < backup_lo) part = 1'b0;
            else if (dl_start >= backup_lo && dl_start < backup_hi) part = 1'b1;
            if (!(dl_start >= main_lo && dl_start < backup_lo) &&
                !(dl_start >= backup_lo && dl_start < backup_hi))
              push_neg(NRC_OUT_OF_RANGE);
            else begin
              pending_results.push_back(mk(KIND_ERASE, 8'd0, 32'd0, part, 32'd0, 1'b0));
              push_resp(SID_DOWNLOAD + POS_OFFSET, 1'b0);
              push_resp(8'h02, 1'b0);
              push_resp(8'h00, 1'b1);
            end
          end
        end
      end
      SID_TRANSFER: begin
        if (len <= 2) push_neg(NRC_BAD_LENGTH);
        else if (second != next_block) push_neg(NRC_WRONG_BLOCK);
        else if (session != SESS_PROGRAMMING) push_neg(NRC_NOT_PROGRAMMING);
        else begin
          next_block = next_block + 8'd1;
          push_resp(SID_TRANSFER + POS_OFFSET, 1'b0);
          push_resp(second, 1'b1);
        end
      end
      SID_EXIT: begin
        pending_results.push_back(mk(KIND_EXIT, 8'd0, 32'd0, 1'b0, crc_acc, 1'b0));
        if (rx_count == dl_len) push_resp(SID_EXIT + POS_OFFSET, 1'b1);
        else push_neg(NRC_COUNT_MISMATCH);
      end
      default: push_neg(NRC_UNKNOWN_SERVICE);
    endcase
  endtask

  task automatic take_byte(logic [10:0] fid, logic [7:0] b, logic last);
    int idx;
    idx = byte_idx;
    if (fid != req_id) return;
    if (idx == 0) begin
      accepted = 1'b1; sid = b; second = 0; addr_len = 0; size_len = 0;
      addr_acc = 0; size_acc = 0; crc_acc = 0;
    end
    if (idx >= MAX_REQUEST_BYTES) accepted = 1'b0;
    if (accepted) begin
      if (idx == 1) second = b;
      if (sid == SID_DOWNLOAD) begin
        if (idx == 2) begin
          addr_len = b[3:0];
          size_len = b[7:4];
        end else if (idx >= 3 && idx < 3 + addr_len) addr_acc = {addr_acc[23:0], b};
        else if (idx >= 3 + addr_len && idx < 3 + addr_len + size_len)
          size_acc = {size_acc[23:0], b};
      end
      if (sid == SID_EXIT && idx >= 1 && idx <= 4)
        crc_acc = crc_acc | (32'(b) << (8 * (4 - idx)));
      if (sid == SID_TRANSFER && idx >= 2 && second == next_block &&
          session == SESS_PROGRAMMING) begin
        pending_results.push_back(mk(KIND_WRITE, b, dl_start + rx_count, part, 32'd0,
                                     1'b0));
        rx_count = rx_count + 1;
      end
    end
    if (last) begin
      if (accepted) serve_request(idx + 1);
      byte_idx = 0;
      accepted = 1'b0;
    end else if (idx < MAX_REQUEST_BYTES) begin
      byte_idx = 9'(idx + 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      req_id = RST_REQUEST_ID; max_size = RST_MAX_DL_SIZE; main_lo = RST_MAIN_START;
      backup_lo = RST_BACKUP_START; backup_hi = RST_BACKUP_END;
      session = 0; byte_idx = 0; sid = 0; second = 0; accepted = 0;
      addr_len = 0; size_len = 0; addr_acc = 0; size_acc = 0; dl_start = 0;
      dl_len = 0; rx_count = 0; next_block = 0; part = 0; crc_acc = 0;
      pending_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_REQUEST_ID:   req_id = cfg_data_i[10:0];
          REG_MAX_DL_SIZE:  max_size = cfg_data_i[23:0];
          REG_MAIN_START:   main_lo = cfg_data_i;
          REG_BACKUP_START: backup_lo = cfg_data_i;
          REG_BACKUP_END:   backup_hi = cfg_data_i;
          default: ;
        endcase
      end
      // output beat checked before the input beat of the same edge is predicted;
      // a same-edge result cannot come from that input beat
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = mk(m_axis_tuser_i, m_axis_tdata_i[7:0], m_axis_tdata_i[39:8],
                 m_axis_tdata_i[40], m_axis_tdata_i[72:41], m_axis_tlast_i);
        if (pending_results.size() == 0) begin
          $display("%0t: expected no beat actual %h", $time, got);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: expected %h actual %h", $time, want, got);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_byte(s_axis_tdata_i[10:0], s_axis_tdata_i[18:11], s_axis_tlast_i);
    end
  end

endmodule

/* bench/testbench.sv */
module testbench;
  import uds_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tlast_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_index_i = '0;
  logic [31:0]           cfg_data_i = '0;
  int                    fail_count, pending;
  int                    cycles = 0;
  bit                    hold_off = 1'b0;

  logic [10:0] cur_id = RST_REQUEST_ID;
  logic [31:0] cur_main = RST_MAIN_START, cur_backup = RST_BACKUP_START;
  logic [31:0] cur_end = RST_BACKUP_END;
  logic [7:0]  blk = 8'd1;

  typedef logic [7:0] byte_q_t[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  uds_bootloader_request_server_top dut (.*);

  uds_server_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tlast_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(
    m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending));

  // receiver stall pattern, with one long hold-off window
  always @(posedge clk_i) begin
    int mode;
    mode = (cycles / 700) % 3;
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (mode == 0) m_axis_tready_i <= 1'b1;
    else if (mode == 1) m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    else m_axis_tready_i <= ($urandom_range(0, 1) != 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("uds_bootloader_request_server_top: mismatch");
      $finish;
    end
  end

  task automatic send_beat(logic [10:0] fid, logic [7:0] b, logic last);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, b, fid};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(byte_q_t bytes);
    foreach (bytes[i]) begin
      // stray foreign bytes are interleaved now and then
      if ($urandom_range(0, 15) == 0) send_beat(cur_id ^ 11'(1 << $urandom_range(0, 10)),
                                               8'($urandom), 1'($urandom));
      send_beat(cur_id, bytes[i], i == bytes.size() - 1);
      idle_gap();
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_layout(logic [31:0] m, logic [31:0] b, logic [31:0] e);
    cur_main = m; cur_backup = b; cur_end = e;
    write_reg(REG_MAIN_START, m);
    write_reg(REG_BACKUP_START, b);
    write_reg(REG_BACKUP_END, e);
  endtask

  function automatic byte_q_t download_frame(logic [31:0] addr, logic [31:0] size);
    byte_q_t q;
    q = {SID_DOWNLOAD, 8'h00, 8'h44, addr[31:24], addr[23:16], addr[15:8], addr[7:0],
         size[31:24], size[23:16], size[15:8], size[7:0]};
    return q;
  endfunction

  function automatic byte_q_t transfer_frame(logic [7:0] b, int n);
    byte_q_t q;
    q = {SID_TRANSFER, b};
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return cur_main;
      1: return cur_backup;
      2: return cur_backup - 1;
      3: return cur_end - 1;
      4: return cur_end;
      default: return cur_main + $urandom_range(0, 'h1000);
    endcase
  endfunction

  task automatic random_frame();
    byte_q_t q;
    int sel, n;
    sel = $urandom_range(0, 19);
    if (sel < 2) q = {SID_SESSION, 8'($urandom_range(0, 4))};
    else if (sel < 3) q = {SID_TESTER, 8'h00};
    else if (sel < 4) q = {SID_RESET, 8'h01};
    else if (sel < 7) begin
      q = download_frame(pick_addr(), $urandom_range(0, 12));
      blk = 8'd1;
      if ($urandom_range(0, 3) == 0) q[2] = 8'($urandom);
    end else if (sel < 14) begin
      n = $urandom_range(1, 6);
      q = transfer_frame(($urandom_range(0, 5) == 0) ? 8'($urandom) : blk, n);
      if (q[1] == blk) blk = blk + 1;
    end else if (sel < 16) begin
      n = $urandom_range(1, 5);
      q = {SID_EXIT};
      repeat (n - 1) q.push_back(8'($urandom));
    end else if (sel < 17) q = {SID_SESSION, 8'h02};
    else begin
      n = $urandom_range(1, 4);
      q = {};
      repeat (n) q.push_back(8'($urandom));
    end
    send_frame(q);
  endtask

  initial begin
    byte_q_t q;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: services, negatives, special cases
    send_frame({SID_TESTER});
    send_frame({SID_RESET});
    send_frame({SID_SESSION});
    send_frame({SID_SESSION, 8'h00});
    send_frame({SID_SESSION, 8'hFF});
    send_frame({8'hFF, 8'hAA});
    send_frame({SID_TRANSFER, 8'h01, 8'h55});
    send_frame({SID_TRANSFER, 8'h01});
    send_frame({SID_SESSION, 8'h02});
    send_frame({SID_DOWNLOAD, 8'h00, 8'h44});
    send_frame(download_frame(cur_main, 32'd4));
    send_frame(transfer_frame(8'd2, 2));
    send_frame(transfer_frame(8'd1, 4));
    send_frame({SID_EXIT, 8'hDE, 8'hAD});
    send_frame({SID_EXIT, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00});
    send_frame(download_frame(cur_end, 32'd1));
    send_frame(download_frame(cur_backup, 32'hFFFF_FFFF));
    send_frame(download_frame(cur_backup, 32'd2));
    send_frame(transfer_frame(8'd1, 2));
    // overlong frame: flash writes stop after the limit
    q = transfer_frame(8'd2, MAX_REQUEST_BYTES + 3);
    send_frame(q);
    send_beat(11'h7FF, 8'hFF, 1'b1);
    send_beat(11'h000, 8'h00, 1'b1);
    drain();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (12) send_frame({SID_TESTER});
    join
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          cur_id = 11'h000; write_reg(REG_REQUEST_ID, 32'h0);
          write_reg(REG_MAX_DL_SIZE, 32'h0);
        end
        1: begin
          cur_id = 11'h7FF; write_reg(REG_REQUEST_ID, 32'h7FF);
          write_reg(REG_MAX_DL_SIZE, 32'hFF_FFFF);
          set_layout(32'hFFFF_FFF8, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        end
        2: begin
          cur_id = 11'(cur_id ^ 11'h555); write_reg(REG_REQUEST_ID, {21'd0, cur_id});
          write_reg(REG_MAX_DL_SIZE, 32'd8);
          set_layout(32'h0, 32'h100, 32'h200);
        end
        3: set_layout(32'h1000, 32'h1000, 32'h800);
        default: begin
          cur_id = RST_REQUEST_ID; write_reg(REG_REQUEST_ID, {21'd0, cur_id});
          write_reg(REG_MAX_DL_SIZE, {8'd0, RST_MAX_DL_SIZE});
          set_layout(RST_MAIN_START, RST_BACKUP_START, RST_BACKUP_END);
        end
      endcase
      send_frame({SID_SESSION, 8'h02});
      repeat (4) random_frame();
      drain();
    end
    if (fail_count == 0) $display("uds_bootloader_request_server_top: match");
    else $display("uds_bootloader_request_server_top: mismatch");
    $finish;
  end

endmodule

/* uds_bootloader_request_server_top.f */
hdl/uds_pkg.sv
hdl/uds_bootloader_request_server_top.sv
hdl/uds_checker.sv
bench/uds_server_checker.sv
bench/testbench.sv
